// ===== hdl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit free-list allocator: sequencer
// states, request and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_BITS = 48;
  localparam int WORD_BITS = 32;
  localparam logic [WORD_BITS-1:0] ARENA_RESET = 32'd65536;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ASCAN,
    S_FSCAN1,
    S_F2PREP,
    S_FSCAN2,
    S_WRITE,
    S_SHSET,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_ARENA_SIZE   = 1'b0,
    CFG_BASE_ADDRESS = 1'b1
  } cfg_idx_t;

  // Compare results for the region entry currently on the RAM read port.
  typedef struct packed {
    logic fit;      // request fits in the entry
    logic smaller;  // entry is smaller than the best so far
    logic front;    // freed range ends where the entry starts
    logic back;     // entry ends where the freed range starts
    logic tail;     // entry ends at the merge target
    logic head;     // entry starts at the merge target
  } match_t;

  typedef struct packed {
    req_t                 kind;
    logic [ADDR_BITS-1:0] size;
    logic [ADDR_BITS-1:0] offset;
  } request_t;

  typedef struct packed {
    logic                 grant;
    status_t              status;
    logic [ADDR_BITS-1:0] offset;
  } result_t;

endpackage

// ===== hdl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfa_match.sv =====
// ----------------------------------------------------------------------------
// bfa_match
// Shared compare unit: one adder forms the end of the scanned region, which the
// back and tail compares use; the other compares take the entry fields directly.
// ----------------------------------------------------------------------------
module bfa_match #(
  parameter int OB = 32
) (
  input  logic [OB-1:0]        e_off,
  input  logic [OB-1:0]        e_size,
  input  logic [OB-1:0]        req_size,
  input  logic [OB-1:0]        req_offset,
  input  logic [OB-1:0]        req_end,
  input  logic [OB-1:0]        best_size,
  input  logic [OB-1:0]        target,
  output bfa_pkg::match_t      m
);

  import bfa_pkg::*;

  logic [OB-1:0] e_end;

  // Region end wraps at the offset width.
  assign e_end = e_off + e_size;

  always_comb begin
    m.fit     = (req_size <= e_size);
    m.smaller = (e_size < best_size);
    m.front   = (req_end == e_off);
    m.back    = (e_end == req_offset);
    m.tail    = (e_end == target);
    m.head    = (e_off == target);
  end

endmodule

// ===== hdl/bfa_engine.sv =====
// ----------------------------------------------------------------------------
// bfa_engine
// Region list sequencer: scans the list in RAM one entry per cycle through the
// shared compare unit, updates entries and closes gaps by shifting entries.
// ----------------------------------------------------------------------------
module bfa_engine #(
  parameter int MAX_REGIONS = 64,
  parameter int OB          = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  bfa_pkg::request_t                request,
  input  logic [bfa_pkg::ADDR_BITS-1:0]    arena,
  input  logic                             take,
  output logic                             idle,
  output logic                             done,
  output bfa_pkg::result_t                 result
);

  import bfa_pkg::*;

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [ADDR_BITS-1:0] ARENA_RESET_EXT = ADDR_BITS'(ARENA_RESET);

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [OB-1:0] rsz, roff, rend;
  logic [CW-1:0] iss;
  logic          pvld;
  logic [IW-1:0] pidx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [OB-1:0] cur_off, cur_sz;
  logic [OB-1:0] tgt_val;
  logic          front_mode;
  logic          rm;
  logic [IW-1:0] rm_idx;
  logic          app;
  logic          res_grant;
  status_t       res_status;
  logic [OB-1:0] res_off;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [2*OB-1:0]   wdata;
  logic [2*OB-1:0]   rdata;
  logic [OB-1:0]     e_off, e_sz;
  match_t            m;
  logic              issue, scan_end, scanning, hit2;

  assign e_off    = rdata[2*OB-1:OB];
  assign e_sz     = rdata[OB-1:0];
  assign issue    = (iss < count);
  assign scan_end = !issue && !pvld;
  assign scanning = (state == S_ASCAN) || (state == S_FSCAN1) ||
                    (state == S_FSCAN2) || (state == S_SHIFT);
  assign hit2     = pvld && (pidx != best_idx) && (front_mode ? m.tail : m.head);

  bfa_ram #(
    .WIDTH (2 * OB),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss[IW-1:0]),
    .rdata (rdata)
  );

  bfa_match #(
    .OB (OB)
  ) u_match (
    .e_off      (e_off),
    .e_size     (e_sz),
    .req_size   (rsz),
    .req_offset (roff),
    .req_end    (rend),
    .best_size  (cur_sz),
    .target     (tgt_val),
    .m          (m)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (request.kind)
            REQ_ALLOC: state_next = S_ASCAN;
            REQ_FREE:  state_next = (request.size[OB-1:0] == '0) ? S_FINISH : S_FSCAN1;
            REQ_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_CLEAR: state_next = S_FINISH;
      S_ASCAN: begin
        if (scan_end) begin
          if (!found) begin
            state_next = S_FINISH;
          end else if (rsz == cur_sz) begin
            state_next = S_SHSET;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_FSCAN1: begin
        if (pvld && (m.front || m.back)) begin
          state_next = S_F2PREP;
        end else if (scan_end) begin
          state_next = (count >= CW'(MAX_REGIONS)) ? S_FINISH : S_WRITE;
        end
      end
      S_F2PREP: state_next = S_FSCAN2;
      S_FSCAN2: begin
        if (hit2 || scan_end) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE:  state_next = rm ? S_SHSET : S_FINISH;
      S_SHSET:  state_next = S_SHIFT;
      S_SHIFT:  state_next = scan_end ? S_FINISH : S_SHIFT;
      S_FINISH: state_next = take ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM write port and status outputs.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = {cur_off, cur_sz};
    case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = {{OB{1'b0}}, ARENA_RESET_EXT[OB-1:0]};
      end
      S_CLEAR: begin
        we    = 1'b1;
        wdata = {{OB{1'b0}}, arena[OB-1:0]};
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = best_idx;
      end
      S_SHIFT: begin
        // Entry m+1 moves down to entry m.
        we    = pvld;
        waddr = pidx - IW'(1);
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  assign idle          = (state == S_IDLE);
  assign done          = (state == S_FINISH);
  assign result.grant  = res_grant;
  assign result.status = res_status;
  assign result.offset = ADDR_BITS'(res_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CW'(1);
      pvld  <= 1'b0;
    end else begin
      state <= state_next;

      if (scanning) begin
        pvld <= issue;
        pidx <= iss[IW-1:0];
        if (issue) begin
          iss <= iss + CW'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            rsz        <= request.size[OB-1:0];
            roff       <= request.offset[OB-1:0];
            rend       <= request.offset[OB-1:0] + request.size[OB-1:0];
            iss        <= '0;
            pvld       <= 1'b0;
            found      <= 1'b0;
            rm         <= 1'b0;
            app        <= 1'b0;
            res_grant  <= 1'b0;
            res_status <= ST_OK;
            res_off    <= '0;
          end
        end
        S_CLEAR: count <= CW'(1);
        S_ASCAN: begin
          if (pvld && m.fit && (!found || m.smaller)) begin
            found    <= 1'b1;
            best_idx <= pidx;
            cur_off  <= e_off;
            cur_sz   <= e_sz;
          end else if (scan_end) begin
            if (!found) begin
              res_status <= ST_NOFIT;
            end else begin
              res_grant <= 1'b1;
              res_off   <= cur_off;
              if (rsz == cur_sz) begin
                rm     <= 1'b1;
                rm_idx <= best_idx;
              end else begin
                cur_off <= cur_off + rsz;
                cur_sz  <= cur_sz - rsz;
              end
            end
          end
        end
        S_FSCAN1: begin
          if (pvld && m.front) begin
            best_idx   <= pidx;
            cur_off    <= roff;
            cur_sz     <= e_sz + rsz;
            front_mode <= 1'b1;
          end else if (pvld && m.back) begin
            best_idx   <= pidx;
            cur_off    <= e_off;
            cur_sz     <= e_sz + rsz;
            front_mode <= 1'b0;
          end else if (scan_end) begin
            if (count >= CW'(MAX_REGIONS)) begin
              res_status <= ST_FULL;
            end else begin
              app      <= 1'b1;
              best_idx <= count[IW-1:0];
              cur_off  <= roff;
              cur_sz   <= rsz;
            end
          end
        end
        S_F2PREP: begin
          // The second partner either ends where the grown region starts or
          // starts where it ends.
          tgt_val <= front_mode ? cur_off : cur_off + cur_sz;
          iss     <= '0;
          pvld    <= 1'b0;
        end
        S_FSCAN2: begin
          if (hit2) begin
            rm     <= 1'b1;
            rm_idx <= pidx;
            cur_sz <= cur_sz + e_sz;
            if (front_mode) begin
              cur_off <= e_off;
            end
          end
        end
        S_WRITE: begin
          if (app) begin
            count <= count + CW'(1);
          end
        end
        S_SHSET: begin
          iss  <= CW'(rm_idx) + CW'(1);
          pvld <= 1'b0;
        end
        S_SHIFT: begin
          if (scan_end) begin
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/best_fit_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_core
// Best-fit allocator over an ordered list of free regions with coalescing of
// freed ranges; holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    write, always ready
//  in       in_valid in_ready req_type req_size        request
//           free_offset
//  out      out_valid out_ready status alloc_offset    one result per request
//           alloc_address
//
// The list lives in a RAM with one read and one write port, scanned one entry
// per cycle. An allocate scans the whole list and, on an exact fit, shifts the
// later entries down over the used one; a free scans for a neighbour, after a
// merge rescans for a second partner and may shift; a clear leaves one region.
// After reset, the S_INIT state writes the initial region before in_ready rises.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds at its end until that is free.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_core #(
  parameter int MAX_REGIONS = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] req_size,
  input  logic [31:0] free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] alloc_offset,
  output logic [47:0] alloc_address
);

  import bfa_pkg::*;

  logic [WORD_BITS-1:0] arena_size;
  logic [ADDR_BITS-1:0] base_address;
  request_t             request;
  result_t              result;
  logic                 eng_idle, eng_done, take, start;

  assign cfg_ready = 1'b1;
  assign in_ready  = eng_idle;
  assign start     = in_valid && in_ready;
  assign take      = !out_valid || out_ready;

  assign request.kind   = req_t'(req_type);
  assign request.size   = ADDR_BITS'(req_size);
  assign request.offset = ADDR_BITS'(free_offset);

  bfa_engine #(
    .MAX_REGIONS (MAX_REGIONS),
    .OB          (OFFSET_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .arena   (ADDR_BITS'(arena_size)),
    .take    (take),
    .idle    (eng_idle),
    .done    (eng_done),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size   <= ARENA_RESET;
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ARENA_SIZE:   arena_size   <= cfg_data[WORD_BITS-1:0];
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register: loaded when the engine finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done && take) begin
      out_valid     <= 1'b1;
      status        <= result.status;
      alloc_offset  <= result.offset[WORD_BITS-1:0];
      alloc_address <= result.grant ? base_address + result.offset : '0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
